### src/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// Types and constants shared by the section container parser and its channels
// ----------------------------------------------------------------------------
package scp_pkg;

    localparam int HDR_LEN      = 16;
    localparam int TYPE_END     = 4;
    localparam int NAME_END     = 12;
    localparam int MAX_SECTIONS = 64;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_SIZE  = 3'd1,
        ST_TRUNC_HDR = 3'd2,
        ST_TRUNC_SEC = 3'd3,
        ST_TOO_MANY  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        MATCH_NONE = 2'd0,
        MATCH_ONE  = 2'd1,
        MATCH_MANY = 2'd2
    } match_t;

    typedef enum logic {
        KIND_RECORD = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef enum logic {
        CFG_MAX_TOTAL   = 1'b0,
        CFG_TARGET_TYPE = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        kind_t        kind;
        logic [31:0]  section_type;
        logic [63:0]  section_name;
        logic [31:0]  section_length;
        logic [31:0]  data_offset;
        logic [5:0]   section_index;
        status_t      status;
        logic [6:0]   section_count;
        match_t       match_state;
        logic [5:0]   match_index;
        logic         last_result;
    } out_item_t;

endpackage

### src/scp_stream_if.sv
// ----------------------------------------------------------------------------
// scp_stream_if
// Valid/ready stream channel carrying one payload item per request
// ----------------------------------------------------------------------------
interface scp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/section_container_parser.sv
// ----------------------------------------------------------------------------
// section_container_parser
// Parses a byte stream of 16-byte section headers and data into records
// ----------------------------------------------------------------------------
// in_ch carries one container byte per request, last_byte flags the final
// byte. out_ch carries one record per completed header (first 64 sections)
// and one final status after last byte; a byte may yield two, record first.
// cfg_we/cfg_index/cfg_data write max_total_bytes (0) and target_type (1);
// write only while no container is in flight.
// Each byte is parsed in the cycle it is taken: header shifts, the data
// countdown and the match tracker update at once, and its results enter a
// four-entry result queue that drives out_ch.
// Throughput is one byte per cycle; in_ch.ready drops only while fewer than
// two queue entries are free, which happens only when out_ch stalls.
// Reset clears the parser state, the queue and sets the registers to their
// defaults (max_total_bytes 16777216, target_type 0). After each last byte
// the parser returns to its reset state, registers keep their values.
// ----------------------------------------------------------------------------
module section_container_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data,
    scp_stream_if.sink          in_ch,
    scp_stream_if.source        out_ch
);

    localparam int QDEPTH = 4;

    logic [31:0] max_total_reg;
    logic [31:0] target_type_reg;

    logic [31:0] offset_reg, offset_next;
    logic [4:0]  hpos_reg, hpos_next;
    logic [31:0] type_reg, type_next;
    logic [63:0] name_reg, name_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] remain_reg, remain_next;
    logic [6:0]  seen_reg, seen_next;
    scp_pkg::status_t err_reg, err_next;
    scp_pkg::match_t  match_reg, match_next;
    logic [5:0]  mpos_reg, mpos_next;

    scp_pkg::out_item_t queue_reg [QDEPTH];
    logic [1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [2:0]  count_reg;

    scp_pkg::out_item_t rec, fin;
    logic        push_rec, push_fin;
    logic        accept, pop;
    logic [3:0]  pos;
    logic [2:0]  name_idx;
    logic [1:0]  size_idx;
    logic [32:0] total;
    logic [31:0] doff;
    scp_pkg::status_t st;

    assign accept = in_ch.valid && in_ch.ready;
    assign pop    = out_ch.valid && out_ch.ready;
    assign in_ch.ready  = (count_reg <= 3'(QDEPTH - 2));
    assign out_ch.valid = (count_reg != 3'd0);
    assign out_ch.data  = queue_reg[rd_ptr_reg];

    assign pos      = hpos_reg[3:0];
    assign name_idx = 3'(pos - 4'(scp_pkg::TYPE_END));
    assign size_idx = 2'(pos - 4'(scp_pkg::NAME_END));
    assign total    = {1'b0, offset_reg} + 33'd1;
    assign doff     = (offset_reg == 32'hFFFF_FFFF) ? offset_reg : offset_reg + 32'd1;

    always_comb
    begin
        offset_next = offset_reg;
        hpos_next   = hpos_reg;
        type_next   = type_reg;
        name_next   = name_reg;
        size_next   = size_reg;
        remain_next = remain_reg;
        seen_next   = seen_reg;
        err_next    = err_reg;
        match_next  = match_reg;
        mpos_next   = mpos_reg;
        push_rec    = 1'b0;
        push_fin    = 1'b0;
        st          = scp_pkg::ST_OK;
        rec         = '0;
        fin         = '0;

        if (accept)
        begin
            if (err_reg == scp_pkg::ST_OK)
            begin
                if (hpos_reg < 5'(scp_pkg::HDR_LEN))
                begin
                    if (pos < 4'(scp_pkg::TYPE_END))
                    begin
                        type_next = {type_reg[23:0], in_ch.data.data_byte};
                    end
                    else if (pos < 4'(scp_pkg::NAME_END))
                    begin
                        name_next[{name_idx, 3'b000} +: 8] = in_ch.data.data_byte;
                    end
                    else
                    begin
                        size_next[{size_idx, 3'b000} +: 8] = in_ch.data.data_byte;
                    end
                    hpos_next = hpos_reg + 5'd1;
                    if (hpos_next == 5'(scp_pkg::HDR_LEN))
                    begin
                        if (seen_reg < 7'(scp_pkg::MAX_SECTIONS))
                        begin
                            push_rec           = 1'b1;
                            rec.kind           = scp_pkg::KIND_RECORD;
                            rec.section_type   = type_next;
                            rec.section_name   = name_next;
                            rec.section_length = size_next;
                            rec.data_offset    = doff;
                            rec.section_index  = seen_reg[5:0];
                            rec.last_result    = !in_ch.data.last_byte;
                            if (type_next == target_type_reg)
                            begin
                                if (match_reg == scp_pkg::MATCH_NONE)
                                begin
                                    match_next = scp_pkg::MATCH_ONE;
                                    mpos_next  = seen_reg[5:0];
                                end
                                else
                                begin
                                    match_next = scp_pkg::MATCH_MANY;
                                end
                            end
                        end
                        remain_next = size_next;
                        type_next   = '0;
                        name_next   = '0;
                        size_next   = '0;
                        if (remain_next == 32'd0)
                        begin
                            seen_next = seen_reg + 7'd1;
                            hpos_next = '0;
                            if (seen_next > 7'(scp_pkg::MAX_SECTIONS))
                            begin
                                err_next = scp_pkg::ST_TOO_MANY;
                            end
                        end
                    end
                end
                else
                begin
                    remain_next = remain_reg - 32'd1;
                    if (remain_next == 32'd0)
                    begin
                        seen_next = seen_reg + 7'd1;
                        hpos_next = '0;
                        if (seen_next > 7'(scp_pkg::MAX_SECTIONS))
                        begin
                            err_next = scp_pkg::ST_TOO_MANY;
                        end
                    end
                end
            end

            if (in_ch.data.last_byte)
            begin
                if (total < 33'(scp_pkg::HDR_LEN) || total > {1'b0, max_total_reg})
                begin
                    st = scp_pkg::ST_BAD_SIZE;
                end
                else if (err_next != scp_pkg::ST_OK)
                begin
                    st = err_next;
                end
                else if (hpos_next == 5'd0)
                begin
                    st = scp_pkg::ST_OK;
                end
                else if (hpos_next < 5'(scp_pkg::HDR_LEN))
                begin
                    st = scp_pkg::ST_TRUNC_HDR;
                end
                else
                begin
                    st = scp_pkg::ST_TRUNC_SEC;
                end
                push_fin        = 1'b1;
                fin.kind        = scp_pkg::KIND_STATUS;
                fin.status      = st;
                fin.last_result = 1'b1;
                if (st == scp_pkg::ST_OK)
                begin
                    fin.section_count = seen_next;
                    fin.match_state   = match_next;
                    fin.match_index   = (match_next == scp_pkg::MATCH_ONE) ? mpos_next : 6'd0;
                end
                offset_next = '0;
                hpos_next   = '0;
                type_next   = '0;
                name_next   = '0;
                size_next   = '0;
                remain_next = '0;
                seen_next   = '0;
                err_next    = scp_pkg::ST_OK;
                match_next  = scp_pkg::MATCH_NONE;
                mpos_next   = '0;
            end
            else if (offset_reg != 32'hFFFF_FFFF)
            begin
                offset_next = offset_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_total_reg   <= 32'd16777216;
            target_type_reg <= '0;
            offset_reg      <= '0;
            hpos_reg        <= '0;
            type_reg        <= '0;
            name_reg        <= '0;
            size_reg        <= '0;
            remain_reg      <= '0;
            seen_reg        <= '0;
            err_reg         <= scp_pkg::ST_OK;
            match_reg       <= scp_pkg::MATCH_NONE;
            mpos_reg        <= '0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    scp_pkg::CFG_MAX_TOTAL:   max_total_reg   <= cfg_data;
                    scp_pkg::CFG_TARGET_TYPE: target_type_reg <= cfg_data;
                    default: ;
                endcase
            end
            offset_reg <= offset_next;
            hpos_reg   <= hpos_next;
            type_reg   <= type_next;
            name_reg   <= name_next;
            size_reg   <= size_next;
            remain_reg <= remain_next;
            seen_reg   <= seen_next;
            err_reg    <= err_next;
            match_reg  <= match_next;
            mpos_reg   <= mpos_next;
            wr_ptr_reg <= wr_ptr_reg + 2'(push_rec) + 2'(push_fin);
            rd_ptr_reg <= rd_ptr_reg + 2'(pop);
            count_reg  <= count_reg + 3'(push_rec) + 3'(push_fin) - 3'(pop);
        end
    end

    // result queue payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (push_rec)
        begin
            queue_reg[wr_ptr_reg] <= rec;
        end
        if (push_fin)
        begin
            queue_reg[wr_ptr_reg + 2'(push_rec)] <= fin;
        end
    end

endmodule
